[rtl/core/ppte_pkg.sv]
// ----------------------------------------------------------------------------
// ppte_pkg: shared types, constants and helpers
// Widths, reset values and saturation helpers for the per-point time line
// estimator and its arithmetic units.
// ----------------------------------------------------------------------------
package ppte_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 24;
  localparam int unsigned TIME_W          = 32;
  localparam int unsigned WEIGHT_W        = 16;
  localparam int unsigned ACC_W           = 64;
  localparam int unsigned WIDE_W          = 2 * ACC_W;
  localparam int unsigned EST_W           = 48;
  localparam int unsigned ROOT_W          = ACC_W / 2;
  localparam int unsigned N3_W            = 48;
  localparam int unsigned NUM_ACC         = 6;
  localparam int unsigned IDX_W           = $clog2(NUM_ACC);

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd3277;
  localparam logic [ACC_W-1:0]    ACC_RESET    = 64'd42950;
  localparam logic [TIME_W-1:0]   ZERO_TIME    = 32'd1;
  localparam int unsigned         ZERO_COUNT   = 100;

  localparam logic [ACC_W-1:0] EST_MAX     = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [ACC_W-1:0] EST_MIN_MAG = 64'h0000_8000_0000_0000;
  localparam logic [ACC_W-1:0] TERM_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;

  // accumulator slots: a, b, c, d, e, f of the quadratic form
  localparam logic [IDX_W-1:0] ACC_XX    = 3'd0;
  localparam logic [IDX_W-1:0] ACC_YY    = 3'd1;
  localparam logic [IDX_W-1:0] ACC_XY    = 3'd2;
  localparam logic [IDX_W-1:0] ACC_X_LIN = 3'd3;
  localparam logic [IDX_W-1:0] ACC_Y_LIN = 3'd4;
  localparam logic [IDX_W-1:0] ACC_CONST = 3'd5;

  function automatic logic [ACC_W-1:0] abs64(input logic [ACC_W-1:0] x);
    return x[ACC_W-1] ? -x : x;
  endfunction

  function automatic logic [WIDE_W-1:0] abs128(input logic [WIDE_W-1:0] x);
    return x[WIDE_W-1] ? -x : x;
  endfunction

  // magnitude quotient to signed Q32.16 with saturation
  function automatic logic [EST_W-1:0] sat_est(input logic [WIDE_W-1:0] q, input logic neg);
    logic [EST_W-1:0] r;
    if (neg) begin
      if (q[WIDE_W-1:ACC_W] != '0 || q[ACC_W-1:0] > EST_MIN_MAG) r = EST_MIN_MAG[EST_W-1:0];
      else r = -q[EST_W-1:0];
    end else begin
      if (q[WIDE_W-1:ACC_W] != '0 || q[ACC_W-1:0] > EST_MAX) r = EST_MAX[EST_W-1:0];
      else r = q[EST_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/ppte_mul.sv]
// ----------------------------------------------------------------------------
// ppte_mul: iterative unsigned multiplier
// Full W x W product built from four half-width partial products.
// ----------------------------------------------------------------------------
module ppte_mul #(
  parameter int unsigned W = ppte_pkg::ACC_W
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic           done_o,
  output logic [2*W-1:0] prod_o
);
  localparam int unsigned HW = W / 2;
  localparam int unsigned PW = 2 * W;
  localparam logic [2:0]  LAST = 3'd4;

  logic [W-1:0]  a_q, b_q, pp_q;
  logic [PW-1:0] acc_q;
  logic [2:0]    cnt_q, cm1;
  logic          busy_q, done_q;
  logic [HW-1:0] a_part, b_part;
  logic [PW-1:0] pp_sh;

  always_comb begin
    a_part = cnt_q[1] ? a_q[W-1:HW] : a_q[HW-1:0];
    b_part = cnt_q[0] ? b_q[W-1:HW] : b_q[HW-1:0];
    cm1    = cnt_q - 3'd1;
    case (cm1[1:0])
      2'd0:    pp_sh = PW'(pp_q);
      2'd3:    pp_sh = PW'(pp_q) << W;
      default: pp_sh = PW'(pp_q) << HW;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      b_q    <= '0;
      pp_q   <= '0;
      acc_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        a_q    <= a_i;
        b_q    <= b_i;
        acc_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (cnt_q != LAST) pp_q <= a_part * b_part;
        if (cnt_q != 3'd0) acc_q <= acc_q + pp_sh;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 3'd1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

[rtl/core/ppte_div.sv]
// ----------------------------------------------------------------------------
// ppte_div: restoring divider
// One quotient bit per cycle; quotient and remainder held after done.
// ----------------------------------------------------------------------------
module ppte_div #(
  parameter int unsigned W = ppte_pkg::WIDE_W
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);
  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  r_q, nq_q, d_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [W:0]    rs, diff;
  logic          ge;

  always_comb begin
    rs   = {r_q, nq_q[W-1]};
    diff = rs - {1'b0, d_q};
    ge   = rs >= {1'b0, d_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q    <= '0;
      nq_q   <= '0;
      d_q    <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        r_q    <= '0;
        nq_q   <= num_i;
        d_q    <= den_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        r_q   <= ge ? diff[W-1:0] : rs[W-1:0];
        nq_q  <= {nq_q[W-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = nq_q;
  assign rem_o  = r_q;

endmodule

[rtl/core/ppte_sqrt.sv]
// ----------------------------------------------------------------------------
// ppte_sqrt: digit-by-digit integer square root
// Floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ppte_sqrt #(
  parameter int unsigned W = ppte_pkg::ACC_W
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   v_i,
  output logic           done_o,
  output logic [W/2-1:0] root_o
);
  localparam int unsigned RW = W / 2;
  localparam int unsigned CW = $clog2(RW);

  logic [W-1:0]    v_q;
  logic [RW+1:0]   rem_q, rs, trial;
  logic [RW-1:0]   root_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q, done_q, ge;

  always_comb begin
    rs    = {rem_q[RW-1:0], v_q[W-1:W-2]};
    trial = {root_q, 2'b01};
    ge    = rs >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        v_q    <= v_i;
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q  <= ge ? rs - trial : rs;
        root_q <= {root_q[RW-2:0], ge};
        v_q    <= v_q << 2;
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == CW'(RW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[rtl/core/per_point_time_line_estimator_core.sv]
// ----------------------------------------------------------------------------
// per_point_time_line_estimator_core: time line estimator top level
// Smooths a quadratic form over measurement lines and reports its minimum.
//
//   port group   dir  fields (low bit first)
//   s_axis       in   point_count, elapsed_time
//   m_axis       out  estimate_x, estimate_y; tuser = degenerate
//   cfg          in   smoothing_weight
//
// Each request runs three 128-step divisions (reciprocal, x, y; the x and y
// divisions are skipped when the determinant is zero), 38 products on the
// shared multiplier and two 32-step square roots.
// s_tready is high only while the sequencer is idle.
// Reset loads the accumulators with 0.00001 and the weight with 3277.
// A stalled result waits in the output register; the next request is taken
// and its sequence holds at the output step until the register is free.
// ----------------------------------------------------------------------------
module per_point_time_line_estimator_core #(
  parameter int unsigned COUNT_WIDTH = ppte_pkg::COUNT_WIDTH_DEF,
  localparam int unsigned IN_W  = ((COUNT_WIDTH + ppte_pkg::TIME_W + 7) / 8) * 8,
  localparam int unsigned OUT_W = 2 * ppte_pkg::EST_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_wr_en_i,
  input  logic [ppte_pkg::WEIGHT_W-1:0] cfg_wr_data_i,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [IN_W-1:0]               s_tdata_i,  // point_count, elapsed_time
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [OUT_W-1:0]              m_tdata_o,  // estimate_x, estimate_y
  output logic                          m_tuser_o   // degenerate
);
  import ppte_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MSQ, ST_RECIP, ST_SQ1, ST_SQ2, ST_TERM, ST_EWMA, ST_DET, ST_QUO, ST_OUT
  } state_e;

  state_e                state_q;
  logic                  go_q;
  logic [WEIGHT_W-1:0]   weight_q;
  logic [COUNT_WIDTH-1:0] cnt_q;
  logic [TIME_W-1:0]     time_q;
  logic [ACC_W-1:0]      m_q, qf_q, qn_q, sum_q;
  logic [ROOT_W-1:0]     n1_q, n2_q;
  logic [N3_W-1:0]       n3_q;
  logic [ACC_W-1:0]      term_q [NUM_ACC];
  logic [ACC_W-1:0]      acc_q  [NUM_ACC];
  logic [IDX_W-1:0]      step_q;
  logic [1:0]            sub_q;
  logic [WIDE_W-1:0]     den_q, numx_q, numy_q;
  logic [EST_W-1:0]      estx_q, esty_q;
  logic                  degen_q;
  logic                  out_valid_q, out_user_q;
  logic [OUT_W-1:0]      out_data_q;

  logic [COUNT_WIDTH-1:0] in_cnt;
  logic [TIME_W-1:0]     in_time;
  logic [ACC_W-1:0]      mul_a, mul_b, op_x, op_y, acc_old, term_new;
  logic                  mul_neg, quo_neg;
  logic [WEIGHT_W:0]     cw;
  logic                  mul_start, mul_done, div_start, div_done, sqrt_start, sqrt_done;
  logic [WIDE_W-1:0]     mul_prod, sprod, div_num, div_den, div_quot, div_rem;
  logic [ACC_W-1:0]      sqrt_v, quot_lo;
  logic [ROOT_W-1:0]     sqrt_root;

  assign in_cnt  = s_tdata_i[COUNT_WIDTH-1:0];
  assign in_time = s_tdata_i[COUNT_WIDTH +: TIME_W];

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_neg  = 1'b0;
    op_x     = '0;
    op_y     = '0;
    acc_old  = acc_q[step_q];
    term_new = term_q[step_q];
    cw       = (WEIGHT_W + 1)'(1 << WEIGHT_W) - (WEIGHT_W + 1)'(weight_q);
    case (state_q)
      ST_MSQ: begin
        mul_a = ACC_W'(cnt_q);
        mul_b = ACC_W'(cnt_q);
      end
      ST_TERM: begin
        case (step_q)
          3'd0:    begin mul_a = ACC_W'(time_q); mul_b = ACC_W'(n1_q); end
          3'd1:    begin mul_a = ACC_W'(n1_q);   mul_b = ACC_W'(n1_q); end
          3'd2:    begin mul_a = ACC_W'(n2_q);   mul_b = ACC_W'(n2_q); end
          3'd3:    begin mul_a = ACC_W'(n1_q);   mul_b = ACC_W'(n2_q); end
          3'd4:    begin mul_a = ACC_W'(n1_q);   mul_b = ACC_W'(n3_q); end
          3'd5:    begin mul_a = ACC_W'(n2_q);   mul_b = ACC_W'(n3_q); end
          default: begin mul_a = ACC_W'(n3_q);   mul_b = ACC_W'(n3_q); end
        endcase
      end
      ST_EWMA: begin
        case (sub_q)
          2'd0:    begin mul_a = ACC_W'(acc_old[15:0]);  mul_b = ACC_W'(cw); end
          2'd1:    begin mul_a = ACC_W'(term_new[15:0]); mul_b = ACC_W'(weight_q); end
          2'd2: begin
            mul_a = {{16{acc_old[ACC_W-1]}}, acc_old[ACC_W-1:16]};
            mul_b = ACC_W'(cw);
          end
          default: begin
            mul_a = {{16{term_new[ACC_W-1]}}, term_new[ACC_W-1:16]};
            mul_b = ACC_W'(weight_q);
          end
        endcase
      end
      ST_DET: begin
        case (step_q)
          3'd0:    begin op_x = acc_q[ACC_XX]; op_y = acc_q[ACC_YY]; end
          3'd1:    begin op_x = acc_q[ACC_XY]; op_y = acc_q[ACC_XY]; end
          3'd2:    begin op_x = acc_q[ACC_XY]; op_y = acc_q[ACC_Y_LIN]; end
          3'd3:    begin op_x = acc_q[ACC_YY]; op_y = acc_q[ACC_X_LIN]; end
          3'd4:    begin op_x = acc_q[ACC_XY]; op_y = acc_q[ACC_X_LIN]; end
          default: begin op_x = acc_q[ACC_XX]; op_y = acc_q[ACC_Y_LIN]; end
        endcase
        mul_a   = abs64(op_x);
        mul_b   = abs64(op_y);
        mul_neg = op_x[ACC_W-1] ^ op_y[ACC_W-1];
      end
      default: ;
    endcase
  end

  assign sprod = mul_neg ? -mul_prod : mul_prod;

  always_comb begin
    if (state_q == ST_QUO) begin
      div_num = abs128(step_q == 3'd0 ? numx_q : numy_q) << 16;
      div_den = abs128(den_q);
    end else begin
      div_num = {{ACC_W{1'b0}}, {ACC_W{1'b1}}};
      div_den = {{ACC_W{1'b0}}, m_q};
    end
    quo_neg = (step_q == 3'd0 ? numx_q[WIDE_W-1] : numy_q[WIDE_W-1]) ^ den_q[WIDE_W-1];
    quot_lo = div_quot[ACC_W-1:0];
    sqrt_v  = (state_q == ST_SQ1) ? qf_q : qn_q;
  end

  assign mul_start  = go_q && (state_q == ST_MSQ || state_q == ST_TERM ||
                               state_q == ST_EWMA || state_q == ST_DET);
  assign div_start  = go_q && (state_q == ST_RECIP || state_q == ST_QUO);
  assign sqrt_start = go_q && (state_q == ST_SQ1 || state_q == ST_SQ2);

  ppte_mul #(.W(ACC_W)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .prod_o(mul_prod)
  );

  ppte_div #(.W(WIDE_W)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_quot), .rem_o(div_rem)
  );

  ppte_sqrt #(.W(ACC_W)) u_sqrt (
    .clk_i, .rst_ni, .start_i(sqrt_start), .v_i(sqrt_v),
    .done_o(sqrt_done), .root_o(sqrt_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      go_q        <= 1'b0;
      weight_q    <= WEIGHT_RESET;
      cnt_q       <= '0;
      time_q      <= '0;
      m_q         <= '0;
      qf_q        <= '0;
      qn_q        <= '0;
      sum_q       <= '0;
      n1_q        <= '0;
      n2_q        <= '0;
      n3_q        <= '0;
      step_q      <= '0;
      sub_q       <= '0;
      den_q       <= '0;
      numx_q      <= '0;
      numy_q      <= '0;
      estx_q      <= '0;
      esty_q      <= '0;
      degen_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_user_q  <= 1'b0;
      out_data_q  <= '0;
      for (int i = 0; i < NUM_ACC; i++) begin
        acc_q[i]  <= ACC_RESET;
        term_q[i] <= '0;
      end
    end else begin
      go_q <= 1'b0;
      if (cfg_wr_en_i) weight_q <= cfg_wr_data_i;
      if (state_q == ST_OUT && (!out_valid_q || m_tready_i)) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_tvalid_i) begin
            cnt_q   <= (in_cnt == '0) ? COUNT_WIDTH'(ZERO_COUNT) : in_cnt;
            time_q  <= (in_time == '0) ? ZERO_TIME : in_time;
            go_q    <= 1'b1;
            state_q <= ST_MSQ;
          end
        end
        ST_MSQ: begin
          if (mul_done) begin
            m_q     <= mul_prod[ACC_W-1:0] + 64'd1;
            go_q    <= 1'b1;
            state_q <= ST_RECIP;
          end
        end
        ST_RECIP: begin
          if (div_done) begin
            qf_q    <= quot_lo + ACC_W'(div_rem[ACC_W-1:0] == m_q - 64'd1);
            qn_q    <= (div_rem[ACC_W-1:0] == m_q - 64'd1) ? -quot_lo
                                                             : -(quot_lo + 64'd1);
            go_q    <= 1'b1;
            state_q <= ST_SQ1;
          end
        end
        ST_SQ1: begin
          if (sqrt_done) begin
            n1_q    <= sqrt_root;
            go_q    <= 1'b1;
            state_q <= ST_SQ2;
          end
        end
        ST_SQ2: begin
          if (sqrt_done) begin
            n2_q    <= sqrt_root;
            step_q  <= '0;
            go_q    <= 1'b1;
            state_q <= ST_TERM;
          end
        end
        ST_TERM: begin
          if (mul_done) begin
            case (step_q)
              3'd0: n3_q <= mul_prod[N3_W+15:16];
              3'd1: term_q[ACC_XX] <= mul_prod[95:32];
              3'd2: term_q[ACC_YY] <= mul_prod[95:32];
              3'd3: term_q[ACC_XY] <= mul_prod[94:31];
              3'd4: term_q[ACC_X_LIN] <= -mul_prod[94:31];
              3'd5: term_q[ACC_Y_LIN] <= -mul_prod[94:31];
              default: begin
                if (mul_prod[127:96] != '0 || mul_prod[95]) term_q[ACC_CONST] <= TERM_MAX;
                else term_q[ACC_CONST] <= mul_prod[95:32];
              end
            endcase
            go_q <= 1'b1;
            if (step_q == 3'd6) begin
              step_q  <= '0;
              sub_q   <= '0;
              state_q <= ST_EWMA;
            end else begin
              step_q <= step_q + 3'd1;
            end
          end
        end
        ST_EWMA: begin
          if (mul_done) begin
            case (sub_q)
              2'd0:    sum_q <= mul_prod[ACC_W-1:0];
              2'd1:    sum_q <= (sum_q + mul_prod[ACC_W-1:0]) >> 16;
              2'd2:    sum_q <= sum_q + mul_prod[ACC_W-1:0];
              default: acc_q[step_q] <= sum_q + mul_prod[ACC_W-1:0];
            endcase
            sub_q <= sub_q + 2'd1;
            go_q  <= 1'b1;
            if (sub_q == 2'd3) begin
              if (step_q == ACC_CONST) begin
                step_q  <= '0;
                state_q <= ST_DET;
              end else begin
                step_q <= step_q + 3'd1;
              end
            end
          end
        end
        ST_DET: begin
          if (mul_done) begin
            case (step_q)
              3'd0:    den_q  <= sprod << 2;
              3'd1:    den_q  <= den_q - sprod;
              3'd2:    numx_q <= sprod;
              3'd3:    numx_q <= numx_q - (sprod << 1);
              3'd4:    numy_q <= sprod;
              default: numy_q <= numy_q - (sprod << 1);
            endcase
            if (step_q == 3'd5) begin
              step_q <= '0;
              if (den_q == '0) begin
                estx_q  <= '0;
                esty_q  <= '0;
                degen_q <= 1'b1;
                state_q <= ST_OUT;
              end else begin
                degen_q <= 1'b0;
                go_q    <= 1'b1;
                state_q <= ST_QUO;
              end
            end else begin
              step_q <= step_q + 3'd1;
              go_q   <= 1'b1;
            end
          end
        end
        ST_QUO: begin
          if (div_done) begin
            if (step_q == 3'd0) begin
              estx_q <= sat_est(div_quot, quo_neg);
              step_q <= 3'd1;
              go_q   <= 1'b1;
            end else begin
              esty_q  <= sat_est(div_quot, quo_neg);
              state_q <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (!out_valid_q || m_tready_i) begin
            out_data_q <= {esty_q, estx_q};
            out_user_q <= degen_q;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_user_q;

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o |-> m_tdata_o == '0)
    else $error("degenerate result with nonzero estimate");

  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({mul_start, div_start, sqrt_start}))
    else $error("two arithmetic units started together");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("ready right after a request");

  a_mul_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_MSQ || state_q == ST_TERM ||
                  state_q == ST_EWMA || state_q == ST_DET))
    else $error("multiplier finished outside a product step");

endmodule

[test/tb_per_point_time_line_estimator_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_per_point_time_line_estimator_core: self-checking regression
// Sends measurements through the stream input and predicts each estimate
// with an independent fixed-point model of the smoothed quadratic form.
// Results are checked field by field, in order, under several idle, stall
// and smoothing weight settings, including a long output hold-off.
// ----------------------------------------------------------------------------
module tb_per_point_time_line_estimator_core;
  import ppte_pkg::*;

  localparam int unsigned CW        = COUNT_WIDTH_DEF;
  localparam int unsigned IN_W      = ((CW + TIME_W + 7) / 8) * 8;
  localparam int unsigned OUT_W     = 2 * EST_W;
  localparam int unsigned LIMIT     = 8000000;
  localparam int unsigned DRAIN_CYC = 1000;

  typedef struct packed {
    logic [EST_W-1:0] est_x;
    logic [EST_W-1:0] est_y;
    logic             degen;
  } estimate_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [WEIGHT_W-1:0] cfg_wr_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_W-1:0]    m_tdata;
  logic                m_tuser;

  per_point_time_line_estimator_core #(.COUNT_WIDTH(CW)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_wr_en_i(cfg_wr_en), .cfg_wr_data_i(cfg_wr_data),
    .s_tvalid_i(s_tvalid), .s_tready_o(s_tready), .s_tdata_i(s_tdata),
    .m_tvalid_o(m_tvalid), .m_tready_i(m_tready), .m_tdata_o(m_tdata),
    .m_tuser_o(m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  estimate_t      pending_est[$];
  int unsigned    errors = 0;
  int unsigned    cycles = 0;
  int unsigned    tx_idle_pct = 0;
  int unsigned    rx_stall_pct = 0;
  int unsigned    rx_hold = 0;

  // model state
  logic [WEIGHT_W-1:0] weight;
  logic [ACC_W-1:0]    q_xx, q_yy, q_xy, q_xl, q_yl, q_c;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("per_point_time_line_estimator_core regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic logic [63:0] sqrt_floor(input logic [127:0] v);
    logic [127:0] res;
    logic [127:0] trial;
    res = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = res | (128'd1 << i);
      if (trial * trial <= v) res = trial;
    end
    return res[63:0];
  endfunction

  function automatic logic [127:0] sprod(input logic [63:0] a, input logic [63:0] b);
    return $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
  endfunction

  function automatic logic [63:0] smooth(input logic [63:0] old, input logic [63:0] term,
                                         input logic [15:0] w);
    logic signed [127:0] s;
    logic [16:0]         cw;
    cw = 17'h10000 - {1'b0, w};
    s = $signed({{64{old[63]}}, old}) * $signed({111'b0, cw})
      + $signed({{64{term[63]}}, term}) * $signed({112'b0, w});
    s = s >>> 16;
    return s[63:0];
  endfunction

  function automatic logic [EST_W-1:0] est_quot(input logic [127:0] num, input logic [127:0] den);
    logic [127:0] mn, md, q;
    mn = num[127] ? -num : num;
    md = den[127] ? -den : den;
    q = (mn << 16) / md;
    if (num[127] != den[127]) begin
      if (q > {64'd0, EST_MIN_MAG}) return EST_MIN_MAG[EST_W-1:0];
      return -q[EST_W-1:0];
    end
    if (q > {64'd0, EST_MAX}) return EST_MAX[EST_W-1:0];
    return q[EST_W-1:0];
  endfunction

  task automatic predict_estimate(input logic [CW-1:0] count, input logic [TIME_W-1:0] tm);
    logic [127:0] two64, m, q, qc, p, den;
    logic [63:0]  n, t, n1, n2, n3, tf;
    estimate_t    e;
    n = (count == 0) ? 64'(ZERO_COUNT) : 64'(count);
    t = (tm == 0) ? 64'(ZERO_TIME) : 64'(tm);
    two64 = 128'd1 << 64;
    m = n * n + 1;
    q = two64 / m;
    qc = ((two64 % m) != 0) ? q + 1 : q - 1;
    n1 = sqrt_floor(q);
    n2 = sqrt_floor(two64 - qc);
    n3 = (t * n1) >> 16;
    q_xx = smooth(q_xx, (n1 * n2 * 0 + n1 * n1) >> 32, weight);
    q_yy = smooth(q_yy, (n2 * n2) >> 32, weight);
    q_xy = smooth(q_xy, (n1 * n2) >> 31, weight);
    p = {64'd0, n1} * {64'd0, n3};
    q_xl = smooth(q_xl, -p[94:31], weight);
    p = {64'd0, n2} * {64'd0, n3};
    q_yl = smooth(q_yl, -p[94:31], weight);
    p = {64'd0, n3} * {64'd0, n3};
    tf = p[95:32];
    if (p[127:96] != 0 || tf[63]) tf = TERM_MAX;
    q_c = smooth(q_c, tf, weight);
    den = (sprod(q_xx, q_yy) << 2) - sprod(q_xy, q_xy);
    if (den == 0) begin
      e = '{est_x: '0, est_y: '0, degen: 1'b1};
    end else begin
      e.est_x = est_quot(sprod(q_xy, q_yl) - (sprod(q_yy, q_xl) << 1), den);
      e.est_y = est_quot(sprod(q_xy, q_xl) - (sprod(q_xx, q_yl) << 1), den);
      e.degen = 1'b0;
    end
    pending_est.push_back(e);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    estimate_t e;
    if (rst_n && m_tvalid && m_tready) begin
      if (pending_est.size() == 0) begin
        report_mismatch("unexpected result", '0, m_tdata[63:0]);
      end else begin
        e = pending_est.pop_front();
        if (m_tdata[EST_W-1:0] !== e.est_x)
          report_mismatch("estimate_x", 64'(e.est_x), 64'(m_tdata[EST_W-1:0]));
        if (m_tdata[OUT_W-1:EST_W] !== e.est_y)
          report_mismatch("estimate_y", 64'(e.est_y), 64'(m_tdata[OUT_W-1:EST_W]));
        if (m_tuser !== e.degen) report_mismatch("degenerate", 64'(e.degen), 64'(m_tuser));
      end
    end
  end

  task automatic send_meas(input logic [CW-1:0] count, input logic [TIME_W-1:0] tm);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_W'({tm, count});
    do @(posedge clk); while (!s_tready);
    predict_estimate(count, tm);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_est.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic set_weight(input logic [WEIGHT_W-1:0] w);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    weight = w;
  endtask

  function automatic logic [CW-1:0] rand_count();
    case ($urandom_range(5))
      0: return '0;
      1: return CW'($urandom_range(1, 20));
      2: return CW'($urandom_range(1, 2000));
      3: return {CW{1'b1}};
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    case ($urandom_range(5))
      0: return '0;
      1: return TIME_W'($urandom_range(1, 255));
      2: return TIME_W'($urandom_range(1, 32'h0010_0000));
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_meas('0, '0);
    send_meas({CW{1'b1}}, '1);
    send_meas(1, 32'h0001_0000);
    send_meas('0, '1);
    send_meas({CW{1'b1}}, '0);
    send_meas(100, 32'h0000_8000);
    set_weight(16'hFFFF);
    send_meas({CW{1'b1}}, 1);
    send_meas({CW{1'b1}}, 1);
    send_meas(1, '1);
    send_meas(2, 32'h8000_0000);
    set_weight(16'h0000);
    send_meas(5, 32'h0003_0000);
    send_meas('0, '0);
    set_weight(16'h8000);
    send_meas(24'h555555, 32'hAAAA_AAAA);
    send_meas(24'hAAAAAA, 32'h5555_5555);
    send_meas(1, 1);
  endtask

  task automatic test_random_phase(input int unsigned idle, input int unsigned stall,
                                   input int unsigned items);
    tx_idle_pct = idle;
    rx_stall_pct = stall;
    set_weight(($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 8000)));
    for (int i = 0; i < items; i++) send_meas(rand_count(), rand_time());
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    wait_drained();
    rx_hold = 4000;
    for (int i = 0; i < 6; i++) send_meas(rand_count(), rand_time());
    wait_drained();
    for (int i = 0; i < 4; i++) send_meas(rand_count(), rand_time());
  endtask

  initial begin
    weight = WEIGHT_RESET;
    q_xx = ACC_RESET; q_yy = ACC_RESET; q_xy = ACC_RESET;
    q_xl = ACC_RESET; q_yl = ACC_RESET; q_c = ACC_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_phase(0, 0, 350);
    test_random_phase(64, 0, 350);
    test_random_phase(0, 64, 350);
    test_random_phase(25, 25, 350);
    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0 && pending_est.size() == 0)
      $display("per_point_time_line_estimator_core regression: pass");
    else
      $display("per_point_time_line_estimator_core regression: fail");
    $finish;
  end

endmodule
